// ===== rtl/core/q6k_pkg.sv =====
// Shared types, constants and float format helpers for the Q6_K dot-product engine.
package q6k_pkg;

   // Command codes of the request channel
   localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd0;
   localparam logic [1:0] CMD_LOAD_ACT    = 2'd1;
   localparam logic [1:0] CMD_ACCUMULATE  = 2'd2;
   localparam logic [1:0] CMD_EMIT        = 2'd3;

   // Weight block layout
   localparam int          BLOCK_BYTES = 210;
   localparam logic [7:0]  HIGH_BASE   = 8'd128;
   localparam logic [7:0]  SCALE_BASE  = 8'd192;
   localparam logic [7:0]  D_LO_ADDR   = 8'd208;
   localparam logic [7:0]  D_HI_ADDR   = 8'd209;
   localparam logic [7:0]  LOW_MASK    = 8'h0f;
   localparam logic [7:0]  Q_OFFSET    = 8'd32;
   localparam int          TOKEN_SLOTS = 8;

   // fp32 constants
   localparam logic [31:0] FP32_DEFAULT_NAN = 32'hffc0_0000;
   localparam logic [31:0] FP32_QUIET_BIT   = 32'h0040_0000;

   typedef enum logic {
      FP_MUL = 1'b0,
      FP_ADD = 1'b1
   } fp_op_type;

   typedef struct packed {
      logic        start;
      fp_op_type   op;
      logic [31:0] a;
      logic [31:0] b;
   } fpu_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } fpu_rsp_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  token;
      logic [15:0] value;
      logic        last;
   } rsp_push_type;

   // Exact conversion of a signed byte to fp32
   function automatic logic [31:0] int_to_fp32(input logic signed [7:0] v);
      logic [8:0]  mag;
      logic [2:0]  pos;
      logic [31:0] tmp;
      logic [31:0] res;
      mag = v[7] ? (9'd0 - {v[7], v}) : {1'b0, v};
      pos = 3'd0;
      for (int j = 0; j < 8; j++) begin
         if (mag[j]) pos = 3'(j);
      end
      tmp = {23'b0, mag} << (5'd23 - {2'b0, pos});
      if (mag == 9'd0) begin
         res = 32'b0;
      end else begin
         res = {v[7], 8'd127 + {5'b0, pos}, tmp[22:0]};
      end
      return res;
   endfunction

   // Exact fp16 to fp32 widening, subnormals normalized
   function automatic logic [31:0] half_to_fp32(input logic [15:0] h);
      logic [4:0]  ex;
      logic [9:0]  man;
      logic [3:0]  pos;
      logic [23:0] tmp;
      logic [31:0] res;
      ex  = h[14:10];
      man = h[9:0];
      pos = 4'd0;
      for (int j = 0; j < 10; j++) begin
         if (man[j]) pos = 4'(j);
      end
      tmp = {14'b0, man} << (5'd23 - {1'b0, pos});
      if (ex == 5'd0) begin
         if (man == 10'd0) res = {h[15], 31'b0};
         else res = {h[15], 8'd103 + {4'b0, pos}, tmp[22:0]};
      end else if (ex == 5'd31) begin
         res = {h[15], 8'hff, man, 13'b0};
      end else begin
         res = {h[15], {3'b0, ex} + 8'd112, man, 13'b0};
      end
      return res;
   endfunction

   // fp32 to fp16, round to nearest even, quiet NaN keeps top mantissa bits
   function automatic logic [15:0] fp32_to_fp16(input logic [31:0] f);
      logic [15:0]       sgn;
      logic [7:0]        ex;
      logic [22:0]       man;
      logic signed [9:0] e;
      logic [23:0]       full;
      logic [23:0]       hs;
      logic [23:0]       mask;
      logic [23:0]       rem;
      logic [23:0]       halfway;
      logic [4:0]        sh;
      logic [15:0]       h;
      logic [12:0]       r;
      logic [15:0]       res;
      sgn  = {f[31], 15'b0};
      ex   = f[30:23];
      man  = f[22:0];
      e    = $signed({2'b0, ex}) - 10'sd112;
      full = {1'b1, man};
      sh   = 5'd0;
      hs   = 24'd0;
      mask = 24'd0;
      rem  = 24'd0;
      halfway = 24'd0;
      h    = 16'd0;
      r    = man[12:0];
      if (ex == 8'hff) begin
         res = sgn | 16'h7c00 | ((man != 23'd0) ? (16'h0200 | {6'b0, man[22:13]}) : 16'h0000);
      end else if (e >= 10'sd31) begin
         res = sgn | 16'h7c00;
      end else if (e <= 10'sd0) begin
         if (e < -10'sd10) begin
            res = sgn;
         end else begin
            sh      = 5'(10'sd14 - e);
            hs      = full >> sh;
            mask    = ~(24'hff_ffff << sh);
            rem     = full & mask;
            halfway = 24'd1 << (sh - 5'd1);
            h       = hs[15:0];
            if ((rem > halfway) || ((rem == halfway) && h[0])) h = h + 16'd1;
            res = sgn | h;
         end
      end else begin
         h = {1'b0, e[4:0], man[22:13]};
         if ((r > 13'h1000) || ((r == 13'h1000) && h[0])) h = h + 16'd1;
         res = sgn | h;
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/q6k_dequant_matvec.sv =====
// Top level of the Q6_K dequantize and dot-product engine.
//
// Load commands are taken while the sequencer is idle. An accumulate command walks the 256
// weights of the stored block through one shared two-stage fp32 multiply/add unit: per
// group of four weights it fetches the bytes and forms the scales, then, for each active
// token, runs three float operations for each of four terms. An emit command sends one
// result per active token, holding while the output register is full, and then clears
// the sums. Sums are fp32 in the order half, index, token, term; results are rounded
// to fp16 to nearest even.
module q6k_dequant_matvec #(
   parameter int MAX_BATCH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_weight_index,
   input  logic [7:0]  req_weight_byte,
   input  logic [2:0]  req_token,
   input  logic [7:0]  req_position,
   input  logic [15:0] req_activation_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_token_index,
   output logic [15:0] rsp_sum_value,
   output logic        rsp_last_of_row,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);
   import q6k_pkg::*;

   localparam int NSLOT = (MAX_BATCH < TOKEN_SLOTS) ? MAX_BATCH : TOKEN_SLOTS;

   logic [3:0]   batch_ff, n_eff;
   fpu_req_type  fpu_req;
   fpu_rsp_type  fpu_rsp;
   rsp_push_type push;
   logic         push_ok;
   logic         rsp_valid_ff;
   logic [2:0]   rsp_token_ff;
   logic [15:0]  rsp_value_ff;
   logic         rsp_last_ff;

   // Batch size register, saturated to the token slots
   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff <= 4'd1;
      end else if (csr_wr_en) begin
         batch_ff <= csr_wr_data;
      end
   end
   assign n_eff = (batch_ff > 4'(NSLOT)) ? 4'(NSLOT) : batch_ff;

   q6k_ctrl #(.NSLOT(NSLOT)) u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_weight_index     (req_weight_index),
      .req_weight_byte      (req_weight_byte),
      .req_token            (req_token),
      .req_position         (req_position),
      .req_activation_value (req_activation_value),
      .n_eff                (n_eff),
      .fpu_req              (fpu_req),
      .fpu_rsp              (fpu_rsp),
      .push_ok              (push_ok),
      .push                 (push)
   );

   q6k_fpu u_fpu (
      .clock (clock),
      .reset (reset),
      .req   (fpu_req),
      .rsp   (fpu_rsp)
   );

   // Output register
   assign push_ok = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (push.valid) begin
         rsp_token_ff <= push.token;
         rsp_value_ff <= push.value;
         rsp_last_ff  <= push.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_token_index = rsp_token_ff;
   assign rsp_sum_value   = rsp_value_ff;
   assign rsp_last_of_row = rsp_last_ff;

`ifndef SYNTH
   // A new result never overwrites one that has not been taken
   assert property (@(posedge clock) disable iff (reset) (push.valid && rsp_valid_ff) |-> rsp_ready)
      else $error("output register overrun");
`endif

endmodule

// ===== rtl/core/q6k_fpu.sv =====
// Shared fp32 multiply/add unit, two stages, round to nearest even.
module q6k_fpu (
   input  logic                 clock,
   input  logic                 reset,
   input  q6k_pkg::fpu_req_type req,
   output q6k_pkg::fpu_rsp_type rsp
);
   import q6k_pkg::*;

   // Operand unpack
   logic [7:0]  ea, eb;
   logic [8:0]  eae, ebe;
   logic [23:0] siga, sigb;
   logic        nana, nanb, infa, infb, zeroa, zerob;

   assign ea    = req.a[30:23];
   assign eb    = req.b[30:23];
   assign eae   = (ea == 8'd0) ? 9'd1 : {1'b0, ea};
   assign ebe   = (eb == 8'd0) ? 9'd1 : {1'b0, eb};
   assign siga  = {ea != 8'd0, req.a[22:0]};
   assign sigb  = {eb != 8'd0, req.b[22:0]};
   assign nana  = (ea == 8'hff) && (req.a[22:0] != 23'd0);
   assign nanb  = (eb == 8'hff) && (req.b[22:0] != 23'd0);
   assign infa  = (ea == 8'hff) && (req.a[22:0] == 23'd0);
   assign infb  = (eb == 8'hff) && (req.b[22:0] == 23'd0);
   assign zeroa = req.a[30:0] == 31'd0;
   assign zerob = req.b[30:0] == 31'd0;

   // Stage 1: multiply or align-and-add
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_spec_ff, s1_spec_in;
   logic [31:0]       s1_specval_ff, s1_specval_in;
   logic              s1_sign_ff, s1_sign_in;
   logic [47:0]       s1_mant_ff, s1_mant_in;
   logic signed [10:0] s1_be_ff, s1_be_in;

   logic        a_big, sx, sy;
   logic [8:0]  ex_e, ey_e, diff;
   logic [26:0] sx27, sy27, sy_sh, sy_mask;
   logic        sy_st;
   logic [27:0] sum28;

   always_comb begin
      a_big   = req.a[30:0] >= req.b[30:0];
      sx      = a_big ? req.a[31] : req.b[31];
      sy      = a_big ? req.b[31] : req.a[31];
      ex_e    = a_big ? eae : ebe;
      ey_e    = a_big ? ebe : eae;
      sx27    = {(a_big ? siga : sigb), 3'b0};
      sy27    = {(a_big ? sigb : siga), 3'b0};
      diff    = ex_e - ey_e;
      sy_mask = 27'd0;
      if (diff >= 9'd27) begin
         sy_sh = 27'd0;
         sy_st = sy27 != 27'd0;
      end else begin
         sy_sh   = sy27 >> diff;
         sy_mask = ~(27'h7ff_ffff << diff);
         sy_st   = (sy27 & sy_mask) != 27'd0;
      end
      if (sx == sy) sum28 = {1'b0, sx27} + {1'b0, sy_sh | {26'b0, sy_st}};
      else          sum28 = {1'b0, sx27} - {1'b0, sy_sh | {26'b0, sy_st}};

      s1_valid_in   = req.start;
      s1_spec_in    = 1'b0;
      s1_specval_in = FP32_DEFAULT_NAN;
      if (req.op == FP_MUL) begin
         s1_sign_in = req.a[31] ^ req.b[31];
         s1_mant_in = siga * sigb;
         s1_be_in   = $signed({2'b0, eae}) + $signed({2'b0, ebe}) - 11'sd126;
         if (nana) begin
            s1_spec_in = 1'b1; s1_specval_in = req.a | FP32_QUIET_BIT;
         end else if (nanb) begin
            s1_spec_in = 1'b1; s1_specval_in = req.b | FP32_QUIET_BIT;
         end else if (infa || infb) begin
            s1_spec_in = 1'b1;
            if (zeroa || zerob) s1_specval_in = FP32_DEFAULT_NAN;
            else s1_specval_in = {s1_sign_in, 8'hff, 23'b0};
         end
      end else begin
         s1_sign_in = ((sum28 == 28'd0) && (sx != sy)) ? 1'b0 : sx;
         s1_mant_in = {20'b0, sum28};
         s1_be_in   = $signed({2'b0, ex_e}) + 11'sd21;
         if (nana) begin
            s1_spec_in = 1'b1; s1_specval_in = req.a | FP32_QUIET_BIT;
         end else if (nanb) begin
            s1_spec_in = 1'b1; s1_specval_in = req.b | FP32_QUIET_BIT;
         end else if (infa && infb && (req.a[31] != req.b[31])) begin
            s1_spec_in = 1'b1; s1_specval_in = FP32_DEFAULT_NAN;
         end else if (infa) begin
            s1_spec_in = 1'b1; s1_specval_in = req.a;
         end else if (infb) begin
            s1_spec_in = 1'b1; s1_specval_in = req.b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_spec_ff    <= s1_spec_in;
      s1_specval_ff <= s1_specval_in;
      s1_sign_ff    <= s1_sign_in;
      s1_mant_ff    <= s1_mant_in;
      s1_be_ff      <= s1_be_in;
   end

   // Stage 2: normalize, round, pack
   logic [5:0]         pos, lz, sh;
   logic [47:0]        nrm, dsh, lostmask;
   logic signed [10:0] be, shv;
   logic [30:0]        field, packd;
   logic               g, st, inc;
   logic [31:0]        res_in, res_ff;
   logic               done_ff;

   always_comb begin
      pos = 6'd0;
      for (int j = 0; j < 48; j++) begin
         if (s1_mant_ff[j]) pos = 6'(j);
      end
      lz       = 6'd47 - pos;
      nrm      = s1_mant_ff << lz;
      be       = s1_be_ff - $signed({5'b0, lz});
      shv      = 11'sd1 - be;
      sh       = 6'd0;
      dsh      = 48'd0;
      lostmask = 48'd0;
      field    = 31'd0;
      g        = 1'b0;
      st       = 1'b0;
      if (be >= 11'sd1) begin
         field = {be[7:0], nrm[46:24]};
         g     = nrm[23];
         st    = nrm[22:0] != 23'd0;
      end else begin
         sh       = (shv > 11'sd26) ? 6'd26 : shv[5:0];
         dsh      = nrm >> sh;
         lostmask = ~(48'hffff_ffff_ffff << sh);
         field    = {8'b0, dsh[46:24]};
         g        = dsh[23];
         st       = (dsh[22:0] != 23'd0) || ((nrm & lostmask) != 48'd0);
      end
      inc   = g & (st | field[0]);
      packd = field + {30'b0, inc};
      if (s1_spec_ff)                  res_in = s1_specval_ff;
      else if (s1_mant_ff == 48'd0)    res_in = {s1_sign_ff, 31'b0};
      else if (be >= 11'sd255)         res_in = {s1_sign_ff, 8'hff, 23'b0};
      else                             res_in = {s1_sign_ff, packd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= s1_valid_ff;
      end
      res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

`ifndef SYNTH
   // A result is flagged only for operands that passed through both stage registers
   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(req.start, 2))
      else $error("fpu result without matching start");
   // The sequencer never issues while an operation is in flight
   assert property (@(posedge clock) disable iff (reset) req.start |=> !req.start)
      else $error("fpu started on consecutive cycles");
`endif

endmodule

// ===== rtl/core/q6k_ctrl.sv =====
// Sequencer, weight/activation memories and per-token fp32 sums.
module q6k_ctrl #(
   parameter int NSLOT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [7:0]            req_weight_index,
   input  logic [7:0]            req_weight_byte,
   input  logic [2:0]            req_token,
   input  logic [7:0]            req_position,
   input  logic [15:0]           req_activation_value,
   input  logic [3:0]            n_eff,
   output q6k_pkg::fpu_req_type  fpu_req,
   input  q6k_pkg::fpu_rsp_type  fpu_rsp,
   input  logic                  push_ok,
   output q6k_pkg::rsp_push_type push
);
   import q6k_pkg::*;

   localparam int TW = (NSLOT > 1) ? $clog2(NSLOT) : 1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_FETCH = 7'b0000010,
      ST_SCALE = 7'b0000100,
      ST_MULQ  = 7'b0001000,
      ST_MULX  = 7'b0010000,
      ST_ADD   = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic        hb_ff, hb_in;
   logic [4:0]  i_ff, i_in;
   logic [3:0]  t_ff, t_in;
   logic [1:0]  k_ff, k_in;
   logic        wait_ff, wait_in;

   logic [7:0]  bytes_ff [9];
   logic [31:0] s_ff [4];
   logic [31:0] p_ff;
   logic [31:0] sum_ff [NSLOT];
   logic [7:0]  wrd_ff;
   logic [15:0] ard_ff;

   logic [7:0]  wmem [BLOCK_BYTES];
   logic [15:0] amem [TOKEN_SLOTS * 256];

   logic        accept, fin, sum_clear;
   logic [7:0]  waddr;
   logic [10:0] aaddr;
   logic [31:0] d_val;
   logic [5:0]  qu;
   logic signed [7:0] qv;
   logic [31:0] cur_sum;

   assign accept  = req_valid && req_ready;
   assign req_ready = state_ff == ST_IDLE;
   assign fin     = wait_ff && fpu_rsp.done;
   assign d_val   = half_to_fp32({bytes_ff[1], bytes_ff[0]});
   assign aaddr   = {t_ff[2:0], hb_ff, k_ff, i_ff};
   assign cur_sum = sum_ff[t_ff[TW-1:0]];

   // Weight byte address per fetch step
   always_comb begin
      case (step_ff)
         4'd0:    waddr = D_LO_ADDR;
         4'd1:    waddr = D_HI_ADDR;
         4'd2:    waddr = HIGH_BASE | {2'b0, hb_ff, i_ff};
         4'd3:    waddr = {1'b0, hb_ff, 1'b0, i_ff};
         4'd4:    waddr = {1'b0, hb_ff, 1'b1, i_ff};
         default: waddr = SCALE_BASE | {4'b0, hb_ff, 2'(step_ff - 4'd5), i_ff[4]};
      endcase
   end

   // Six-bit quant of term k, minus the offset
   always_comb begin
      case (k_ff)
         2'd0:    qu = {bytes_ff[2][1:0], bytes_ff[3][3:0]};
         2'd1:    qu = {bytes_ff[2][3:2], bytes_ff[4][3:0]};
         2'd2:    qu = {bytes_ff[2][5:4], 4'(bytes_ff[3] >> 4)};
         default: qu = {bytes_ff[2][7:6], 4'(bytes_ff[4] >> 4)};
      endcase
      qv = $signed({2'b0, qu} - Q_OFFSET);
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      hb_in     = hb_ff;
      i_in      = i_ff;
      t_in      = t_ff;
      k_in      = k_ff;
      wait_in   = wait_ff;
      sum_clear = 1'b0;
      fpu_req.start = 1'b0;
      fpu_req.op    = FP_MUL;
      fpu_req.a     = s_ff[k_ff];
      fpu_req.b     = int_to_fp32(qv);
      push.valid = 1'b0;
      push.token = t_ff[2:0];
      push.value = fp32_to_fp16(cur_sum);
      push.last  = (t_ff + 4'd1) == n_eff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_ACCUMULATE) && (n_eff != 4'd0)) begin
               state_in = ST_FETCH;
               step_in  = 4'd0;
               hb_in    = 1'b0;
               i_in     = 5'd0;
            end else if (accept && (req_cmd == CMD_EMIT)) begin
               state_in = ST_EMIT;
               t_in     = 4'd0;
            end
         end
         ST_FETCH: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd9) begin
               state_in = ST_SCALE;
               k_in     = 2'd0;
            end
         end
         ST_SCALE: begin
            fpu_req.start = !wait_ff;
            fpu_req.a     = d_val;
            fpu_req.b     = int_to_fp32($signed(bytes_ff[4'd5 + {2'b0, k_ff}]));
            wait_in       = !fin;
            if (fin) begin
               k_in = k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  state_in = ST_MULQ;
                  t_in     = 4'd0;
               end
            end
         end
         ST_MULQ: begin
            fpu_req.start = !wait_ff;
            wait_in       = !fin;
            if (fin) state_in = ST_MULX;
         end
         ST_MULX: begin
            fpu_req.start = !wait_ff;
            fpu_req.a     = p_ff;
            fpu_req.b     = half_to_fp32(ard_ff);
            wait_in       = !fin;
            if (fin) state_in = ST_ADD;
         end
         ST_ADD: begin
            fpu_req.start = !wait_ff;
            fpu_req.op    = FP_ADD;
            fpu_req.a     = cur_sum;
            fpu_req.b     = p_ff;
            wait_in       = !fin;
            if (fin) begin
               state_in = ST_MULQ;
               k_in     = k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  t_in = t_ff + 4'd1;
                  if ((t_ff + 4'd1) == n_eff) begin
                     t_in     = 4'd0;
                     state_in = ST_FETCH;
                     step_in  = 4'd0;
                     i_in     = i_ff + 5'd1;
                     if (i_ff == 5'd31) begin
                        hb_in = 1'b1;
                        if (hb_ff) state_in = ST_IDLE;
                     end
                  end
               end
            end
         end
         ST_EMIT: begin
            if (t_ff == n_eff) begin
               sum_clear = 1'b1;
               state_in  = ST_IDLE;
            end else if (push_ok) begin
               push.valid = 1'b1;
               t_in       = t_ff + 4'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 4'd0;
         hb_ff    <= 1'b0;
         i_ff     <= 5'd0;
         t_ff     <= 4'd0;
         k_ff     <= 2'd0;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         hb_ff    <= hb_in;
         i_ff     <= i_in;
         t_ff     <= t_in;
         k_ff     <= k_in;
         wait_ff  <= wait_in;
      end
   end

   // Per-token sums
   always_ff @(posedge clock) begin
      if (reset || sum_clear) begin
         for (int j = 0; j < NSLOT; j++) sum_ff[j] <= 32'd0;
      end else if ((state_ff == ST_ADD) && fin) begin
         sum_ff[t_ff[TW-1:0]] <= fpu_rsp.result;
      end
   end

   // Datapath holding registers
   always_ff @(posedge clock) begin
      if ((state_ff == ST_FETCH) && (step_ff != 4'd0)) begin
         bytes_ff[step_ff - 4'd1] <= wrd_ff;
      end
      if ((state_ff == ST_SCALE) && fin) s_ff[k_ff] <= fpu_rsp.result;
      if (((state_ff == ST_MULQ) || (state_ff == ST_MULX)) && fin) p_ff <= fpu_rsp.result;
   end

   // Weight memory
   always_ff @(posedge clock) begin
      if (accept && (req_cmd == CMD_LOAD_WEIGHT) && (req_weight_index < 8'(BLOCK_BYTES))) begin
         wmem[req_weight_index] <= req_weight_byte;
      end
      wrd_ff <= wmem[waddr];
   end

   // Activation memory
   always_ff @(posedge clock) begin
      if (accept && (req_cmd == CMD_LOAD_ACT)) begin
         amem[{req_token, req_position}] <= req_activation_value;
      end
      ard_ff <= amem[aaddr];
   end

`ifndef SYNTH
   // Emitted tokens stay within the active batch
   assert property (@(posedge clock) disable iff (reset) push.valid |-> (t_ff < n_eff))
      else $error("emit beyond active batch");
   // The last result of a row is followed by the clear, not another result
   assert property (@(posedge clock) disable iff (reset) (push.valid && push.last) |=> !push.valid)
      else $error("result after last of row");
   // A float operation finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset) fpu_rsp.done |-> wait_ff)
      else $error("unexpected fpu result");
`endif

endmodule
